// ----- rtl/core/kce_pkg.sv -----
// Shared types, constants and codes of the k-means clustering engine.
`timescale 1ns / 1ps

package kce_pkg;

  // Sizes of the engine
  localparam int MAX_PATTERNS   = 1024;
  localparam int MAX_CLUSTERS   = 8;
  localparam int MAX_DIMENSIONS = 8;
  localparam int COORD_WIDTH    = 16;
  localparam int MAX_ITERATIONS = 65535;

  localparam int PAT_IW = $clog2(MAX_PATTERNS);
  localparam int DIM_IW = $clog2(MAX_DIMENSIONS);
  localparam int CL_IW  = $clog2(MAX_CLUSTERS);
  localparam int PAT_AW = PAT_IW + DIM_IW;
  localparam int CEN_AW = CL_IW + DIM_IW;

  localparam int NP_W   = $clog2(MAX_PATTERNS + 1);
  localparam int K_W    = $clog2(MAX_CLUSTERS + 1);
  localparam int D_W    = $clog2(MAX_DIMENSIONS + 1);
  localparam int ITER_W = 16;
  localparam int LAB_W  = 4;
  localparam int FRAC   = 8;
  localparam int CEN_W  = 24;
  localparam int SUM_W  = 34;
  localparam int DIFF_W = CEN_W + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int DIST_W = SQ_W + DIM_IW;
  localparam int CNT_W  = NP_W;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 16;

  localparam logic [LAB_W-1:0] LABEL_NONE = LAB_W'(8);

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_SEED  = 2'd1,
    KIND_RUN   = 2'd2,
    KIND_QUERY = 2'd3
  } kind_e;

  typedef enum logic [CFG_IW-1:0] {
    CFG_NUM_PATTERNS   = 2'd0,
    CFG_NUM_CLUSTERS   = 2'd1,
    CFG_MAX_ITERATIONS = 2'd2,
    CFG_DIMENSIONS     = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CEN_W_SEED = 1'b0,
    CEN_W_MEAN = 1'b1
  } cen_wsel_e;

  typedef enum logic {
    SUM_W_CLEAR = 1'b0,
    SUM_W_ACC   = 1'b1
  } sum_wsel_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SEED_RD,
    ST_SEED_WR,
    ST_QRY_RD,
    ST_QRY_OUT,
    ST_A_LAB,
    ST_A_RD,
    ST_A_MUL,
    ST_A_ACC,
    ST_A_CMP,
    ST_A_WR,
    ST_A_END,
    ST_U_CLR,
    ST_U_LAB,
    ST_U_CHK,
    ST_U_RD,
    ST_U_ADD,
    ST_U_DCL,
    ST_U_DRD,
    ST_U_DIV,
    ST_U_DWAIT,
    ST_U_END,
    ST_O_RD,
    ST_O_OUT
  } st_e;

  typedef struct packed {
    kind_e                   kind;
    logic [PAT_IW-1:0]       pattern_index;
    logic [DIM_IW-1:0]       coordinate;
    logic signed [COORD_WIDTH-1:0] value;
    logic [CL_IW-1:0]        cluster;
  } in_item_t;

  typedef struct packed {
    logic [CL_IW-1:0]        cluster_res;
    logic [DIM_IW-1:0]       coordinate_res;
    logic signed [CEN_W-1:0] centroid_value;
    logic [LAB_W-1:0]        label;
    logic [ITER_W-1:0]       iterations;
    logic                    last;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                    pat_we;
    logic                    pat_re;
    logic [PAT_AW-1:0]       pat_addr;
    logic signed [COORD_WIDTH-1:0] pat_wdata;
    logic                    cen_we;
    logic                    cen_re;
    cen_wsel_e               cen_wsel;
    logic [CEN_AW-1:0]       cen_addr;
    logic                    sum_we;
    logic                    sum_re;
    sum_wsel_e               sum_wsel;
    logic [CEN_AW-1:0]       sum_addr;
    logic                    lab_we;
    logic                    lab_re;
    logic [PAT_IW-1:0]       lab_addr;
    logic                    sq_en;
    logic                    dist_clr;
    logic                    dist_acc;
    logic                    best_take;
    logic                    first_c;
    logic                    cnt_clr;
    logic                    cnt_inc;
    logic                    div_start;
    logic                    out_cen;
    logic                    out_lab;
    logic                    lab_none;
    logic                    out_last;
    logic [CL_IW-1:0]        cl;
    logic [DIM_IW-1:0]       dim;
    logic [ITER_W-1:0]       iters;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [LAB_W-1:0] lab;
    logic             lab_changed;
    logic             cnt_zero;
    logic             div_done;
    logic             out_free;
  } dp_sts_t;

endpackage

// ----- rtl/core/kce_div.sv -----
// Restoring divider for the cluster means, one quotient bit per cycle.
`timescale 1ns / 1ps

module kce_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [kce_pkg::SUM_W-1:0] dividend_i,
  input  logic [kce_pkg::CNT_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [kce_pkg::SUM_W-1:0] quotient_o
);
  import kce_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic [STEP_W-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  rem_q;
  logic [SUM_W-1:0]  quo_q;
  logic [CNT_W-1:0]  dvs_q;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    trial;
  logic              fits;

  // Shift in the next dividend bit and try the subtraction
  assign shifted = {rem_q, quo_q[SUM_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_W'(SUM_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/core/kce_datapath.sv -----
// Datapath: pattern, label, centroid and sum memories, distance and mean logic.
`timescale 1ns / 1ps

module kce_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kce_pkg::dp_cmd_t    cmd_i,
  output kce_pkg::dp_sts_t    sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output kce_pkg::out_item_t  out_item_o
);
  import kce_pkg::*;

  localparam int PAT_DEPTH = MAX_PATTERNS * MAX_DIMENSIONS;
  localparam int CEN_DEPTH = MAX_CLUSTERS * MAX_DIMENSIONS;

  logic signed [COORD_WIDTH-1:0] pat_mem [PAT_DEPTH];
  logic [LAB_W-1:0]              lab_mem [MAX_PATTERNS];
  logic signed [CEN_W-1:0]       cen_mem [CEN_DEPTH];
  logic signed [SUM_W-1:0]       sum_mem [CEN_DEPTH];

  logic signed [COORD_WIDTH-1:0] pat_rd_q;
  logic [LAB_W-1:0]              lab_rd_q;
  logic signed [CEN_W-1:0]       cen_raw_q;
  logic                          cen_rv_q;
  logic [CEN_DEPTH-1:0]          cen_vld_q;
  logic signed [SUM_W-1:0]       sum_rd_q;
  logic signed [CEN_W-1:0]       cen_rd;

  logic signed [DIFF_W-1:0]      diff;
  logic signed [SQ_W-1:0]        sq_full;
  logic [SQ_W-1:0]               sq_q;
  logic [DIST_W-1:0]             dist_q;
  logic [DIST_W-1:0]             best_q;
  logic [CL_IW-1:0]              bi_q;

  logic [CNT_W-1:0]              cnt_q [MAX_CLUSTERS];
  logic [SUM_W-1:0]              sum_abs;
  logic [SUM_W-1:0]              dividend;
  logic                          div_done;
  logic [SUM_W-1:0]              quotient;
  logic signed [CEN_W-1:0]       mean;
  logic signed [CEN_W-1:0]       seed_val;
  logic signed [CEN_W-1:0]       cen_wdata;
  logic signed [SUM_W-1:0]       sum_wdata;

  logic                          out_valid_q;
  out_item_t                     out_q;
  logic                          out_free;

  // Pattern store
  always_ff @(posedge clk_i) begin
    if (cmd_i.pat_we) begin
      pat_mem[cmd_i.pat_addr] <= cmd_i.pat_wdata;
    end
    if (cmd_i.pat_re) begin
      pat_rd_q <= pat_mem[cmd_i.pat_addr];
    end
  end

  // Label store
  always_ff @(posedge clk_i) begin
    if (cmd_i.lab_we) begin
      lab_mem[cmd_i.lab_addr] <= LAB_W'(bi_q);
    end
    if (cmd_i.lab_re) begin
      lab_rd_q <= lab_mem[cmd_i.lab_addr];
    end
  end

  // Centroid store; an entry never written reads as zero
  assign seed_val  = CEN_W'(pat_rd_q) <<< FRAC;
  assign cen_wdata = (cmd_i.cen_wsel == CEN_W_MEAN) ? mean : seed_val;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cen_we) begin
      cen_mem[cmd_i.cen_addr] <= cen_wdata;
    end
    if (cmd_i.cen_re) begin
      cen_raw_q <= cen_mem[cmd_i.cen_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_vld_q <= '0;
      cen_rv_q  <= 1'b0;
    end else begin
      if (cmd_i.cen_we) begin
        cen_vld_q[cmd_i.cen_addr] <= 1'b1;
      end
      if (cmd_i.cen_re) begin
        cen_rv_q <= cen_vld_q[cmd_i.cen_addr];
      end
    end
  end

  assign cen_rd = cen_rv_q ? cen_raw_q : '0;

  // Cluster sums
  assign sum_wdata = (cmd_i.sum_wsel == SUM_W_ACC) ?
                     sum_rd_q + (SUM_W'(pat_rd_q) <<< FRAC) : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_we) begin
      sum_mem[cmd_i.sum_addr] <= sum_wdata;
    end
    if (cmd_i.sum_re) begin
      sum_rd_q <= sum_mem[cmd_i.sum_addr];
    end
  end

  // Squared distance: multiply, then accumulate
  assign diff    = (DIFF_W'(pat_rd_q) <<< FRAC) - DIFF_W'(cen_rd);
  assign sq_full = diff * diff;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_en) begin
      sq_q <= sq_full;
    end
    if (cmd_i.dist_clr) begin
      dist_q <= '0;
    end else if (cmd_i.dist_acc) begin
      dist_q <= dist_q + DIST_W'(sq_q);
    end
    // Keep the nearest cluster, the lower index on a tie
    if (cmd_i.best_take && (cmd_i.first_c || dist_q < best_q)) begin
      best_q <= dist_q;
      bi_q   <= cmd_i.cl;
    end
  end

  // Member counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (cmd_i.cnt_clr) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (cmd_i.cnt_inc) begin
      cnt_q[lab_rd_q[CL_IW-1:0]] <= cnt_q[lab_rd_q[CL_IW-1:0]] + 1'b1;
    end
  end

  // Rounded mean, halves away from zero
  assign sum_abs  = sum_rd_q[SUM_W-1] ? SUM_W'(-sum_rd_q) : SUM_W'(sum_rd_q);
  assign dividend = sum_abs + SUM_W'(cnt_q[cmd_i.cl] >> 1);
  assign mean     = sum_rd_q[SUM_W-1] ? -$signed(quotient[CEN_W-1:0])
                                      : $signed(quotient[CEN_W-1:0]);

  kce_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (cnt_q[cmd_i.cl]),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Output register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_cen || cmd_i.out_lab) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_cen) begin
      out_q.cluster_res    <= cmd_i.cl;
      out_q.coordinate_res <= cmd_i.dim;
      out_q.centroid_value <= cen_rd;
      out_q.label          <= '0;
      out_q.iterations     <= cmd_i.iters;
      out_q.last           <= cmd_i.out_last;
    end else if (cmd_i.out_lab) begin
      out_q.cluster_res    <= '0;
      out_q.coordinate_res <= '0;
      out_q.centroid_value <= '0;
      out_q.label          <= cmd_i.lab_none ? LABEL_NONE : lab_rd_q;
      out_q.iterations     <= cmd_i.iters;
      out_q.last           <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Status
  assign sts_o.lab         = lab_rd_q;
  assign sts_o.lab_changed = lab_rd_q != LAB_W'(bi_q);
  assign sts_o.cnt_zero    = cnt_q[cmd_i.cl] == '0;
  assign sts_o.div_done    = div_done;
  assign sts_o.out_free    = out_free;

endmodule

// ----- rtl/core/kce_ctrl.sv -----
// Controller: configuration registers, loop counters and the sequencing FSM.
`timescale 1ns / 1ps

module kce_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  kce_pkg::in_item_t            in_item_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [kce_pkg::CFG_IW-1:0]   cfg_index_i,
  input  logic [kce_pkg::CFG_DW-1:0]   cfg_wdata_i,
  output kce_pkg::dp_cmd_t             cmd_o,
  input  kce_pkg::dp_sts_t             sts_i
);
  import kce_pkg::*;

  st_e               state_q, state_d;
  in_item_t          item_q, item_d;
  logic [PAT_IW-1:0] p_q, p_d;
  logic [CL_IW-1:0]  c_q, c_d;
  logic [DIM_IW-1:0] j_q, j_d;
  logic [ITER_W-1:0] it_q, it_d;
  logic              chg_q, chg_d;
  logic              first_q, first_d;
  logic              ran_q, ran_d;
  logic [NP_W-1:0]   last_np_q, last_np_d;

  logic [NP_W-1:0]   np_q;
  logic [K_W-1:0]    k_q;
  logic [ITER_W-1:0] mi_q;
  logic [D_W-1:0]    d_q;

  logic [NP_W-1:0]   np_eff;
  logic [K_W-1:0]    k_eff;
  logic [D_W-1:0]    d_eff;
  logic [ITER_W-1:0] mi_eff;
  logic              last_p, last_c, last_j;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      np_q <= NP_W'(1);
      k_q  <= K_W'(2);
      mi_q <= ITER_W'(100);
      d_q  <= D_W'(2);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_NUM_PATTERNS:   np_q <= cfg_wdata_i[NP_W-1:0];
        CFG_NUM_CLUSTERS:   k_q  <= cfg_wdata_i[K_W-1:0];
        CFG_MAX_ITERATIONS: mi_q <= cfg_wdata_i[ITER_W-1:0];
        CFG_DIMENSIONS:     d_q  <= cfg_wdata_i[D_W-1:0];
        default:            ;
      endcase
    end
  end

  // Clamp the values in use into their ranges
  assign np_eff = (np_q == '0) ? NP_W'(1) :
                  (np_q > NP_W'(MAX_PATTERNS)) ? NP_W'(MAX_PATTERNS) : np_q;
  assign k_eff  = (k_q == '0) ? K_W'(1) :
                  (k_q > K_W'(MAX_CLUSTERS)) ? K_W'(MAX_CLUSTERS) : k_q;
  assign d_eff  = (d_q == '0) ? D_W'(1) :
                  (d_q > D_W'(MAX_DIMENSIONS)) ? D_W'(MAX_DIMENSIONS) : d_q;
  assign mi_eff = (mi_q == '0) ? ITER_W'(1) : mi_q;

  assign last_p = p_q == PAT_IW'(np_eff - 1'b1);
  assign last_c = c_q == CL_IW'(k_eff - 1'b1);
  assign last_j = j_q == DIM_IW'(d_eff - 1'b1);

  // State and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      p_q       <= '0;
      c_q       <= '0;
      j_q       <= '0;
      it_q      <= '0;
      chg_q     <= 1'b0;
      first_q   <= 1'b0;
      ran_q     <= 1'b0;
      last_np_q <= '0;
    end else begin
      state_q   <= state_d;
      p_q       <= p_d;
      c_q       <= c_d;
      j_q       <= j_d;
      it_q      <= it_d;
      chg_q     <= chg_d;
      first_q   <= first_d;
      ran_q     <= ran_d;
      last_np_q <= last_np_d;
    end
  end

  // Hold the accepted transaction
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  // Next state and counter updates
  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    p_d       = p_q;
    c_d       = c_q;
    j_d       = j_q;
    it_d      = it_q;
    chg_d     = chg_q;
    first_d   = first_q;
    ran_d     = ran_q;
    last_np_d = last_np_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d = in_item_i;
          j_d    = '0;
          unique case (in_item_i.kind)
            KIND_LOAD:  state_d = ST_LOAD;
            KIND_SEED:  state_d = ST_SEED_RD;
            KIND_QUERY: state_d = ST_QRY_RD;
            KIND_RUN: begin
              ran_d     = 1'b1;
              last_np_d = np_eff;
              it_d      = '0;
              first_d   = 1'b1;
              chg_d     = 1'b0;
              p_d       = '0;
              state_d   = ST_A_LAB;
            end
          endcase
        end
      end
      ST_LOAD:    state_d = ST_IDLE;
      ST_SEED_RD: state_d = ST_SEED_WR;
      ST_SEED_WR: begin
        if (&j_q) begin
          state_d = ST_IDLE;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_SEED_RD;
        end
      end
      ST_QRY_RD:  state_d = ST_QRY_OUT;
      ST_QRY_OUT: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      // Assign phase
      ST_A_LAB: begin
        c_d     = '0;
        j_d     = '0;
        state_d = ST_A_RD;
      end
      ST_A_RD:  state_d = ST_A_MUL;
      ST_A_MUL: state_d = ST_A_ACC;
      ST_A_ACC: begin
        if (last_j) begin
          state_d = ST_A_CMP;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_A_RD;
        end
      end
      ST_A_CMP: begin
        if (last_c) begin
          state_d = ST_A_WR;
        end else begin
          c_d     = c_q + 1'b1;
          j_d     = '0;
          state_d = ST_A_RD;
        end
      end
      ST_A_WR: begin
        if (first_q || sts_i.lab_changed) begin
          chg_d = 1'b1;
        end
        if (last_p) begin
          state_d = ST_A_END;
        end else begin
          p_d     = p_q + 1'b1;
          state_d = ST_A_LAB;
        end
      end
      ST_A_END: begin
        it_d    = it_q + 1'b1;
        c_d     = '0;
        j_d     = '0;
        state_d = chg_q ? ST_U_CLR : ST_O_RD;
      end
      // Update phase
      ST_U_CLR: begin
        {c_d, j_d} = {c_q, j_q} + 1'b1;
        if (&{c_q, j_q}) begin
          p_d     = '0;
          state_d = ST_U_LAB;
        end
      end
      ST_U_LAB: state_d = ST_U_CHK;
      ST_U_CHK: begin
        if (sts_i.lab < LAB_W'(k_eff)) begin
          j_d     = '0;
          state_d = ST_U_RD;
        end else if (last_p) begin
          c_d     = '0;
          state_d = ST_U_DCL;
        end else begin
          p_d     = p_q + 1'b1;
          state_d = ST_U_LAB;
        end
      end
      ST_U_RD: state_d = ST_U_ADD;
      ST_U_ADD: begin
        if (!last_j) begin
          j_d     = j_q + 1'b1;
          state_d = ST_U_RD;
        end else if (last_p) begin
          c_d     = '0;
          state_d = ST_U_DCL;
        end else begin
          p_d     = p_q + 1'b1;
          state_d = ST_U_LAB;
        end
      end
      ST_U_DCL: begin
        j_d = '0;
        if (!sts_i.cnt_zero) begin
          state_d = ST_U_DRD;
        end else if (last_c) begin
          state_d = ST_U_END;
        end else begin
          c_d = c_q + 1'b1;
        end
      end
      ST_U_DRD: state_d = ST_U_DIV;
      ST_U_DIV: state_d = ST_U_DWAIT;
      ST_U_DWAIT: begin
        if (sts_i.div_done) begin
          if (!last_j) begin
            j_d     = j_q + 1'b1;
            state_d = ST_U_DRD;
          end else if (last_c) begin
            state_d = ST_U_END;
          end else begin
            c_d     = c_q + 1'b1;
            state_d = ST_U_DCL;
          end
        end
      end
      ST_U_END: begin
        c_d = '0;
        j_d = '0;
        if (it_q < mi_eff) begin
          p_d     = '0;
          first_d = 1'b0;
          chg_d   = 1'b0;
          state_d = ST_A_LAB;
        end else begin
          state_d = ST_O_RD;
        end
      end
      // Emit the centroids
      ST_O_RD: state_d = ST_O_OUT;
      ST_O_OUT: begin
        if (sts_i.out_free) begin
          if (!last_j) begin
            j_d     = j_q + 1'b1;
            state_d = ST_O_RD;
          end else if (last_c) begin
            state_d = ST_IDLE;
          end else begin
            c_d     = c_q + 1'b1;
            j_d     = '0;
            state_d = ST_O_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.pat_addr  = {p_q, j_q};
    cmd_o.pat_wdata = item_q.value;
    cmd_o.cen_addr  = {c_q, j_q};
    cmd_o.cen_wsel  = CEN_W_SEED;
    cmd_o.sum_addr  = {c_q, j_q};
    cmd_o.sum_wsel  = SUM_W_CLEAR;
    cmd_o.lab_addr  = p_q;
    cmd_o.cl        = c_q;
    cmd_o.dim       = j_q;
    cmd_o.iters     = it_q;
    cmd_o.first_c   = c_q == '0;
    cmd_o.out_last  = last_c && last_j;
    cmd_o.lab_none  = !(ran_q && (NP_W'(item_q.pattern_index) < last_np_q));
    in_ready_o      = 1'b0;
    unique case (state_q)
      ST_IDLE:    in_ready_o = 1'b1;
      ST_LOAD: begin
        cmd_o.pat_we   = 1'b1;
        cmd_o.pat_addr = {item_q.pattern_index, item_q.coordinate};
      end
      ST_SEED_RD: begin
        cmd_o.pat_re   = 1'b1;
        cmd_o.pat_addr = {item_q.pattern_index, j_q};
      end
      ST_SEED_WR: begin
        cmd_o.cen_we   = 1'b1;
        cmd_o.cen_addr = {item_q.cluster, j_q};
      end
      ST_QRY_RD: begin
        cmd_o.lab_re   = 1'b1;
        cmd_o.lab_addr = item_q.pattern_index;
      end
      ST_QRY_OUT: cmd_o.out_lab = sts_i.out_free;
      ST_A_LAB: begin
        cmd_o.lab_re   = 1'b1;
        cmd_o.dist_clr = 1'b1;
      end
      ST_A_RD: begin
        cmd_o.pat_re = 1'b1;
        cmd_o.cen_re = 1'b1;
      end
      ST_A_MUL:   cmd_o.sq_en = 1'b1;
      ST_A_ACC:   cmd_o.dist_acc = 1'b1;
      ST_A_CMP: begin
        cmd_o.best_take = 1'b1;
        cmd_o.dist_clr  = 1'b1;
      end
      ST_A_WR:    cmd_o.lab_we = 1'b1;
      ST_A_END:   ;
      ST_U_CLR: begin
        cmd_o.sum_we  = 1'b1;
        cmd_o.cnt_clr = 1'b1;
      end
      ST_U_LAB:   cmd_o.lab_re = 1'b1;
      ST_U_CHK:   cmd_o.cnt_inc = sts_i.lab < LAB_W'(k_eff);
      ST_U_RD: begin
        cmd_o.pat_re   = 1'b1;
        cmd_o.sum_re   = 1'b1;
        cmd_o.sum_addr = {sts_i.lab[CL_IW-1:0], j_q};
      end
      ST_U_ADD: begin
        cmd_o.sum_we   = 1'b1;
        cmd_o.sum_wsel = SUM_W_ACC;
        cmd_o.sum_addr = {sts_i.lab[CL_IW-1:0], j_q};
      end
      ST_U_DCL:   ;
      ST_U_DRD:   cmd_o.sum_re = 1'b1;
      ST_U_DIV:   cmd_o.div_start = 1'b1;
      ST_U_DWAIT: begin
        cmd_o.cen_we   = sts_i.div_done;
        cmd_o.cen_wsel = CEN_W_MEAN;
      end
      ST_U_END:   ;
      ST_O_RD:    cmd_o.cen_re = 1'b1;
      ST_O_OUT:   cmd_o.out_cen = sts_i.out_free;
      default:    ;
    endcase
  end

endmodule

// ----- rtl/core/kmeans_clustering_engine_top.sv -----
// Load writes one coordinate, seed copies a pattern to a centroid, and query
// sends a label to the output register. Run: each round's assign pass uses the
// single distance multiplier; an update clears the sums, adds up the members
// and divides each nonempty cluster on the one-bit-per-cycle divider; then the
// centroids go out. One transaction is worked at a time; the output register
// holds one waiting result, and a further result stalls the controller.
// Reset is asynchronous and active low; labels read as none until a run.
`timescale 1ns / 1ps

module kmeans_clustering_engine_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  kce_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output kce_pkg::out_item_t          out_item_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [kce_pkg::CFG_IW-1:0]  cfg_index_i,
  input  logic [kce_pkg::CFG_DW-1:0]  cfg_wdata_i
);
  import kce_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  kce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  kce_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- rtl/core/kce_checker.sv -----
// Port-level checks of the clustering engine and their bind to the top level.
`timescale 1ns / 1ps

module kce_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input kce_pkg::in_item_t           in_item_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input kce_pkg::out_item_t          out_item_o
);
  import kce_pkg::*;

  // A result stays offered until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  // A run transaction keeps the input closed in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.kind == KIND_RUN |=> !in_ready_o)
    else $error("input open right after a run was accepted");

  // A query answer carries no centroid and closes its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.label != '0 |->
      out_item_o.cluster_res == '0 && out_item_o.coordinate_res == '0 &&
      out_item_o.centroid_value == '0 && out_item_o.last)
    else $error("query answer mixed with centroid fields");

  // A label is a cluster index or none
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.label <= LABEL_NONE)
    else $error("label out of range");

endmodule

bind kmeans_clustering_engine_top kce_checker u_kce_checker (.*);

// ----- bench/tb_kmeans_clustering_engine_top.sv -----
// Self-checking bench for the k-means clustering engine: predicted labels, centroids and counts.
`timescale 1ns / 1ps

module tb_kmeans_clustering_engine_top;
  import kce_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 60;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready_o;
  in_item_t in_item = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  out_item_t out_item_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  kmeans_clustering_engine_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  // Mirror of the engine state
  int pat_mem[MAX_PATTERNS][MAX_DIMENSIONS];
  logic [LAB_W-1:0] lab_mem[MAX_PATTERNS];
  longint cen_mem[MAX_CLUSTERS][MAX_DIMENSIONS];
  logic [ITER_W-1:0] iter_cnt = '0;
  logic [10:0] reg_np = 11'd1;
  logic [3:0] reg_k = 4'd2;
  logic [15:0] reg_mi = 16'd100;
  logic [3:0] reg_d = 4'd2;

  in_item_t pending_q[$];
  out_item_t expected_q[$];
  int mismatches = 0;
  bit calm = 1'b0;
  bit hold_kick = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Run Lloyd rounds on the mirror and queue the centroid dump
  function automatic void predict_run();
    int np, k, d, mi, it, changes, best_c;
    longint unsigned sq_dist, best, a, n, q;
    longint diff, sum[MAX_CLUSTERS][MAX_DIMENSIONS];
    int cnt[MAX_CLUSTERS];
    out_item_t r;
    np = clamp(int'(reg_np), 1, MAX_PATTERNS);
    k  = clamp(int'(reg_k), 1, MAX_CLUSTERS);
    d  = clamp(int'(reg_d), 1, MAX_DIMENSIONS);
    mi = clamp(int'(reg_mi), 1, MAX_ITERATIONS);
    foreach (lab_mem[p]) lab_mem[p] = LABEL_NONE;
    it = 0;
    do begin
      // assign: nearest centroid, ties to the lower index
      changes = 0;
      for (int p = 0; p < np; p++) begin
        best = 0;
        best_c = 0;
        for (int c = 0; c < k; c++) begin
          sq_dist = 0;
          for (int j = 0; j < d; j++) begin
            diff = longint'(pat_mem[p][j]) * 256 - cen_mem[c][j];
            a = (diff < 0) ? longint'(-diff) : diff;
            sq_dist += a * a;
          end
          if (c == 0 || sq_dist < best) begin
            best = sq_dist;
            best_c = c;
          end
        end
        if (lab_mem[p] != LAB_W'(best_c)) begin
          lab_mem[p] = LAB_W'(best_c);
          changes++;
        end
      end
      // update: rounded member mean, empty clusters keep their centroid
      if (changes > 0) begin
        foreach (cnt[c]) begin
          cnt[c] = 0;
          foreach (sum[c][j]) sum[c][j] = 0;
        end
        for (int p = 0; p < np; p++) begin
          if (lab_mem[p] < LAB_W'(k)) begin
            cnt[lab_mem[p]]++;
            for (int j = 0; j < d; j++) sum[lab_mem[p]][j] += longint'(pat_mem[p][j]) * 256;
          end
        end
        for (int c = 0; c < k; c++) begin
          if (cnt[c] != 0) begin
            n = cnt[c];
            for (int j = 0; j < d; j++) begin
              a = (sum[c][j] < 0) ? longint'(-sum[c][j]) : sum[c][j];
              q = (a + n / 2) / n;
              cen_mem[c][j] = (sum[c][j] < 0) ? -longint'(q) : longint'(q);
            end
          end
        end
      end
      it++;
    end while (it < mi && changes > 0);
    iter_cnt = ITER_W'(it);
    for (int c = 0; c < k; c++) begin
      for (int j = 0; j < d; j++) begin
        r.cluster_res    = CL_IW'(c);
        r.coordinate_res = DIM_IW'(j);
        r.centroid_value = CEN_W'(cen_mem[c][j]);
        r.label          = '0;
        r.iterations     = iter_cnt;
        r.last           = (c == k - 1) && (j == d - 1);
        expected_q = {expected_q, r};
      end
    end
  endfunction

  // Apply one accepted transaction to the mirror
  function automatic void predict_item(in_item_t it);
    out_item_t r;
    case (it.kind)
      KIND_LOAD: pat_mem[it.pattern_index][it.coordinate] = int'(it.value);
      KIND_SEED: begin
        for (int j = 0; j < MAX_DIMENSIONS; j++)
          cen_mem[it.cluster][j] = longint'(pat_mem[it.pattern_index][j]) * 256;
      end
      KIND_QUERY: begin
        r = '0;
        r.label      = lab_mem[it.pattern_index];
        r.iterations = iter_cnt;
        r.last       = 1'b1;
        expected_q = {expected_q, r};
      end
      default: predict_run();
    endcase
  endfunction

  // Driver: advance the pending queue, idle at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) predict_item(in_item);
      if (!in_valid || in_ready_o) begin
        if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 28)) begin
          in_item  <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction, stall at random or on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transaction: %p", out_item_o);
        end else begin
          if (out_item_o.cluster_res !== expected_q[0].cluster_res ||
              out_item_o.coordinate_res !== expected_q[0].coordinate_res ||
              out_item_o.centroid_value !== expected_q[0].centroid_value ||
              out_item_o.label !== expected_q[0].label ||
              out_item_o.iterations !== expected_q[0].iterations ||
              out_item_o.last !== expected_q[0].last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p, got %p", expected_q[0], out_item_o);
          end
          void'(expected_q.pop_front());
        end
      end
      if (hold_kick != hold_seen) begin
        hold_seen <= hold_kick;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 28);
      end
    end
  end

  // Watchdog: count cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** kmeans_clustering_engine_top: FAILED **");
        $finish;
      end
    end
  end

  function automatic void push_load(int pi, int co, int v);
    in_item_t it;
    it = '0;
    it.kind = KIND_LOAD;
    it.pattern_index = PAT_IW'(pi);
    it.coordinate = DIM_IW'(co);
    it.value = COORD_WIDTH'(v);
    pending_q = {pending_q, it};
  endfunction

  function automatic void push_cmd(kind_e kind, int pi, int cl);
    in_item_t it;
    it = '0;
    it.kind = kind;
    it.pattern_index = PAT_IW'(pi);
    it.cluster = CL_IW'(cl);
    it.value = COORD_WIDTH'($urandom);
    it.coordinate = DIM_IW'($urandom);
    pending_q = {pending_q, it};
  endfunction

  // Coordinates mostly grouped around a few centers, sometimes full range
  function automatic int pick_value();
    if ($urandom_range(4) == 0) return int'($signed(16'($urandom)));
    return ($urandom_range(3) * 4000 - 6000) + int'($urandom_range(600)) - 300;
  endfunction

  // Wait until the pending queue is sent and every expected result has come, then let it settle
  task automatic drain();
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, int v);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DW'(v);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_NUM_PATTERNS:   reg_np = 11'(v);
      CFG_NUM_CLUSTERS:   reg_k  = 4'(v);
      CFG_MAX_ITERATIONS: reg_mi = 16'(v);
      default:            reg_d  = 4'(v);
    endcase
  endtask

  task automatic set_config(int np, int k, int mi, int d);
    cfg_write(CFG_NUM_PATTERNS, np);
    cfg_write(CFG_NUM_CLUSTERS, k);
    cfg_write(CFG_MAX_ITERATIONS, mi);
    cfg_write(CFG_DIMENSIONS, d);
  endtask

  // Stimulus and end of run
  initial begin
    int kind_pick;
    foreach (lab_mem[p]) lab_mem[p] = LABEL_NONE;
    foreach (cen_mem[c, j]) cen_mem[c][j] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: labels before any run, extreme values, seeding
    push_cmd(KIND_QUERY, 0, 0);
    push_cmd(KIND_QUERY, 1023, 0);
    push_load(0, 0, 32767);
    push_load(0, 1, -32768);
    for (int j = 2; j < MAX_DIMENSIONS; j++) push_load(0, j, (j % 2) ? -1 : 0);
    for (int p = 1; p < 8; p++)
      for (int j = 0; j < MAX_DIMENSIONS; j++) push_load(p, j, pick_value());
    push_load(1023, 7, 21845);
    push_cmd(KIND_RUN, 0, 0);
    push_cmd(KIND_SEED, 0, 7);
    push_cmd(KIND_SEED, 3, 0);
    push_cmd(KIND_RUN, 0, 0);
    push_cmd(KIND_QUERY, 0, 0);
    push_cmd(KIND_QUERY, 1023, 0);
    drain();

    // Directed: no iteration limit to speak of on a tiny set
    set_config(4, 2, 65535, 2);
    push_cmd(KIND_SEED, 1, 1);
    push_cmd(KIND_RUN, 0, 0);
    push_cmd(KIND_QUERY, 3, 0);
    drain();

    // Directed: largest K and D under a long output stall
    set_config(8, 8, 12, 8);
    for (int c = 0; c < MAX_CLUSTERS; c++) push_cmd(KIND_SEED, c, c);
    push_cmd(KIND_RUN, 0, 0);
    for (int i = 0; i < 4; i++) push_cmd(KIND_QUERY, i * 2, 0);
    @(posedge clk_i iff out_valid_o);
    hold_kick = ~hold_kick;
    drain();

    // Directed: zero registers clamp to the low end
    set_config(0, 0, 0, 0);
    push_cmd(KIND_RUN, 0, 0);
    push_cmd(KIND_QUERY, 0, 0);
    drain();

    // Directed: oversized registers clamp high; no run, the store is mostly unwritten
    set_config(2047, 15, 1, 15);
    push_cmd(KIND_QUERY, 5, 0);
    push_cmd(KIND_QUERY, 1023, 0);
    drain();

    // Random phases of well-formed traffic with random content
    for (int ph = 0; ph < 3; ph++) begin
      set_config($urandom_range(8, 2), $urandom_range(8, 1),
                 ($urandom_range(3) == 0) ? 1 : $urandom_range(12, 2), $urandom_range(8, 1));
      calm = (ph == 1);
      for (int i = 0; i < 5; i++) begin
        kind_pick = $urandom_range(9);
        if (kind_pick < 4)
          push_load($urandom_range(7), $urandom_range(7), pick_value());
        else if (kind_pick == 4)
          push_load($urandom_range(1023), $urandom_range(7), pick_value());
        else if (kind_pick < 7)
          push_cmd(KIND_SEED, $urandom_range(7), $urandom_range(7));
        else if (kind_pick == 7)
          push_cmd(KIND_RUN, 0, 0);
        else
          push_cmd(KIND_QUERY, ($urandom_range(3) == 0) ? $urandom_range(1023)
                                                        : $urandom_range(7), 0);
      end
      push_cmd(KIND_RUN, 0, 0);
      drain();
    end
    calm = 1'b0;

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("** kmeans_clustering_engine_top: PASSED **");
    end else begin
      $display("** kmeans_clustering_engine_top: FAILED **");
    end
    $finish;
  end

endmodule
